// File: design/rsc_pkg.sv
`timescale 1ns / 1ps

package rsc_pkg;

    localparam int MAGNITUDE_BITS_DEF = 31;
    localparam int MAX_DIGITS_DEF     = 32;

    localparam int CHAR_W   = 8;
    localparam int SEL_W    = 2;
    localparam int DIGIT_W  = 4;
    localparam int RADIX_W  = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    typedef enum logic [SEL_W-1:0] {
        RADIX_BIN = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_DEC = 2'd2,
        RADIX_HEX = 2'd3
    } t_radix_sel;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_RADIX = 1'b0,
        CFG_DST_RADIX = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_DIGIT = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_RD,
        S_OUT
    } t_state;

    function automatic logic [RADIX_W-1:0] radix_value(input logic [SEL_W-1:0] sel);
        logic [RADIX_W-1:0] r;
        case (sel)
            RADIX_BIN: r = 5'd2;
            RADIX_OCT: r = 5'd8;
            RADIX_DEC: r = 5'd10;
            RADIX_HEX: r = 5'd16;
            default:   r = 5'd10;
        endcase
        return r;
    endfunction

    // 16 means not a digit in any base
    function automatic logic [RADIX_W-1:0] char_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] t;
        logic [RADIX_W-1:0] v;
        t = CH_NUL;
        v = 5'd16;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            t = c - CH_ZERO;
            v = t[RADIX_W-1:0];
        end else if (c >= CH_UA && c <= CH_UF) begin
            t = c - CH_UA + 8'd10;
            v = t[RADIX_W-1:0];
        end else if (c >= CH_LA && c <= CH_LF) begin
            t = c - CH_LA + 8'd10;
            v = t[RADIX_W-1:0];
        end
        return v;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'd0, d};
        end else begin
            c = CH_UA + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

// File: design/rsc_ram.sv
`timescale 1ns / 1ps

module rsc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/rsc_divider.sv
`timescale 1ns / 1ps

// restoring divide by a small radix, one quotient bit per cycle
module rsc_divider #(
    parameter int MAGNITUDE_BITS = rsc_pkg::MAGNITUDE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [MAGNITUDE_BITS-1:0]     i_dividend,
    input  logic [rsc_pkg::RADIX_W-1:0]   i_radix,
    output logic                          o_done,
    output logic [MAGNITUDE_BITS-1:0]     o_quotient,
    output logic [rsc_pkg::DIGIT_W-1:0]   o_remainder
);

    import rsc_pkg::*;

    localparam int CNT_W = $clog2(MAGNITUDE_BITS + 1);

    logic [MAGNITUDE_BITS-1:0] r_q, n_q;
    logic [DIGIT_W-1:0]        r_rem, n_rem;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic                      r_done, n_done;
    logic [RADIX_W-1:0]        r_radix, n_radix;
    logic [RADIX_W-1:0]        trial;
    logic [RADIX_W-1:0]        diff;
    logic                      ge;

    always_comb begin
        trial = {r_rem, r_q[MAGNITUDE_BITS-1]};
        ge    = trial >= r_radix;
        diff  = trial - r_radix;
    end

    always_comb begin
        n_q     = r_q;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_radix = r_radix;
        n_done  = 1'b0;
        if (i_start) begin
            n_q     = i_dividend;
            n_rem   = '0;
            n_radix = i_radix;
            n_cnt   = CNT_W'(MAGNITUDE_BITS);
        end else if (r_cnt != '0) begin
            n_q   = {r_q[MAGNITUDE_BITS-2:0], ge};
            n_rem = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_q     <= n_q;
        r_rem   <= n_rem;
        r_radix <= n_radix;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;

endmodule

// File: design/radix_string_converter_core.sv
`timescale 1ns / 1ps

// Characters of a number go in on start while busy is low, one per cycle, and are
// checked and accumulated at once; only the character marked last makes the block
// busy. An input error (bad digit or overflow) comes out as a single strobe on
// o_valid in the cycle after that last character. Otherwise a restoring divider
// peels off the output digits, least significant first, into a small digit RAM;
// then the sign (if any) and the digits are sent most significant first, each by a
// RAM read, then the output register. Too many output characters end in an overflow
// error strobe instead. The receiver cannot stall: each result is on the ports for
// exactly one cycle, and is lost if not taken.
module radix_string_converter_core #(
    parameter int MAGNITUDE_BITS = rsc_pkg::MAGNITUDE_BITS_DEF,
    parameter int MAX_DIGITS     = rsc_pkg::MAX_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rsc_pkg::CHAR_W-1:0]    i_char_code,
    input  logic                          i_last_char,
    input  logic                          i_cfg_we,
    input  logic [rsc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rsc_pkg::SEL_W-1:0]     i_cfg_data,
    output logic                          o_valid,
    output logic [rsc_pkg::CHAR_W-1:0]    o_out_char,
    output logic                          o_out_last,
    output logic [1:0]                    o_status
);

    import rsc_pkg::*;

    localparam int MB    = MAGNITUDE_BITS;
    localparam int AW    = $clog2(MAX_DIGITS);
    localparam int NDW   = $clog2(MAX_DIGITS + 1);
    localparam int EXT_W = MB + 4;

    t_state             r_state, n_state;
    logic [SEL_W-1:0]   r_src_sel, r_dst_sel;
    logic [MB-1:0]      r_mag, n_mag;
    logic               r_neg, n_neg;
    logic               r_first, n_first;
    t_status            r_err, n_err;
    logic [NDW-1:0]     r_cnt, n_cnt;

    logic               r_valid, n_valid;
    logic [CHAR_W-1:0]  r_out_char, n_out_char;
    logic               r_out_last, n_out_last;
    t_status            r_status, n_status;

    // accumulate path
    logic [RADIX_W-1:0] d_val, src_b;
    logic [EXT_W-1:0]   mag_x, prod, sum;
    logic [MB-1:0]      acc_mag;
    logic               acc_neg;
    t_status            acc_err;
    logic               accept;

    // conversion path
    logic               div_start, div_done;
    logic [MB-1:0]      div_dividend, div_q;
    logic [DIGIT_W-1:0] div_rem;
    logic [NDW-1:0]     cnt_inc, cnt_dec;
    logic [NDW:0]       out_len;
    logic               conv_more, conv_ovf;
    logic               ram_we;
    logic [DIGIT_W-1:0] ram_rdata;

    assign accept = start && !busy;
    assign busy   = r_state != S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_sel <= RADIX_DEC;
            r_dst_sel <= RADIX_HEX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SRC_RADIX: r_src_sel <= i_cfg_data;
                CFG_DST_RADIX: r_dst_sel <= i_cfg_data;
                default:       r_src_sel <= r_src_sel;
            endcase
        end
    end

    always_comb begin
        d_val = char_value(i_char_code);
        src_b = radix_value(r_src_sel);
        mag_x = {4'd0, r_mag};
        case (r_src_sel)
            RADIX_BIN: prod = mag_x << 1;
            RADIX_OCT: prod = mag_x << 3;
            RADIX_DEC: prod = (mag_x << 3) + (mag_x << 1);
            RADIX_HEX: prod = mag_x << 4;
            default:   prod = mag_x;
        endcase
        sum = prod + EXT_W'(d_val);

        acc_mag = r_mag;
        acc_neg = r_neg;
        acc_err = r_err;
        if (r_err == ST_OK) begin
            if (r_first && i_char_code == CH_MINUS) begin
                acc_neg = 1'b1;
            end else if (d_val >= src_b) begin
                acc_err = ST_BAD_DIGIT;
            end else if (sum[EXT_W-1:MB] != '0) begin
                acc_err = ST_OVERFLOW;
            end else begin
                acc_mag = sum[MB-1:0];
            end
        end
    end

    always_comb begin
        cnt_inc   = r_cnt + 1'b1;
        cnt_dec   = r_cnt - 1'b1;
        out_len   = {1'b0, cnt_inc} + (NDW+1)'(r_neg);
        conv_more = (div_q != '0) && (cnt_inc < NDW'(MAX_DIGITS));
        conv_ovf  = (div_q != '0) || (out_len > (NDW+1)'(MAX_DIGITS));
        div_dividend = (r_state == S_IDLE) ? acc_mag : div_q;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_last_char && acc_err == ST_OK) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (conv_more) begin
                        n_state = S_DIV;
                    end else if (conv_ovf) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: n_state = S_OUT;
            S_OUT: begin
                if (r_cnt == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_mag      = r_mag;
        n_neg      = r_neg;
        n_first    = r_first;
        n_err      = r_err;
        n_cnt      = r_cnt;
        n_valid    = 1'b0;
        n_out_char = r_out_char;
        n_out_last = r_out_last;
        n_status   = r_status;
        div_start  = 1'b0;
        ram_we     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!i_last_char) begin
                        n_mag   = acc_mag;
                        n_neg   = acc_neg;
                        n_err   = acc_err;
                        n_first = 1'b0;
                    end else begin
                        n_mag   = '0;
                        n_first = 1'b1;
                        n_err   = ST_OK;
                        n_cnt   = '0;
                        if (acc_err != ST_OK) begin
                            n_neg      = 1'b0;
                            n_valid    = 1'b1;
                            n_out_char = CH_NUL;
                            n_out_last = 1'b1;
                            n_status   = acc_err;
                        end else begin
                            n_neg     = acc_neg;
                            div_start = 1'b1;
                        end
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    ram_we = 1'b1;
                    n_cnt  = cnt_inc;
                    if (conv_more) begin
                        div_start = 1'b1;
                    end else if (conv_ovf) begin
                        n_neg      = 1'b0;
                        n_valid    = 1'b1;
                        n_out_char = CH_NUL;
                        n_out_last = 1'b1;
                        n_status   = ST_OVERFLOW;
                    end else if (r_neg) begin
                        n_valid    = 1'b1;
                        n_out_char = CH_MINUS;
                        n_out_last = 1'b0;
                        n_status   = ST_OK;
                    end
                end
            end
            S_RD: begin
                n_cnt = cnt_dec;
            end
            S_OUT: begin
                n_valid    = 1'b1;
                n_out_char = digit_char(ram_rdata);
                n_out_last = r_cnt == '0;
                n_status   = ST_OK;
                if (r_cnt == '0) begin
                    n_neg = 1'b0;
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mag   <= '0;
            r_neg   <= 1'b0;
            r_first <= 1'b1;
            r_err   <= ST_OK;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mag   <= n_mag;
            r_neg   <= n_neg;
            r_first <= n_first;
            r_err   <= n_err;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        r_status   <= n_status;
    end

    rsc_divider #(
        .MAGNITUDE_BITS(MAGNITUDE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_radix    (radix_value(r_dst_sel)),
        .o_done     (div_done),
        .o_quotient (div_q),
        .o_remainder(div_rem)
    );

    rsc_ram #(
        .WIDTH(DIGIT_W),
        .DEPTH(MAX_DIGITS)
    ) u_digits (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_cnt[AW-1:0]),
        .i_wdata(div_rem),
        .i_raddr(cnt_dec[AW-1:0]),
        .o_rdata(ram_rdata)
    );

    assign o_valid    = r_valid;
    assign o_out_char = r_out_char;
    assign o_out_last = r_out_last;
    assign o_status   = r_status;

endmodule

// File: design/rsc_checker.sv
`timescale 1ns / 1ps

module rsc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [rsc_pkg::CHAR_W-1:0]    i_char_code,
    input logic                          i_last_char,
    input logic                          i_cfg_we,
    input logic [rsc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input logic [rsc_pkg::SEL_W-1:0]     i_cfg_data,
    input logic                          o_valid,
    input logic [rsc_pkg::CHAR_W-1:0]    o_out_char,
    input logic                          o_out_last,
    input logic [1:0]                    o_status
);

    import rsc_pkg::*;

    // an error transaction is a lone, final, null character
    a_err_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_out_last && o_out_char == CH_NUL)
        else $error("error transaction not final or not null");

    // results only follow a last character or conversion work
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && !(start && i_last_char) |=> !o_valid)
        else $error("transaction without a finished number");

    // more results pending means the block is still converting
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_last |-> busy)
        else $error("non-final transaction while idle");

    // the final result frees the block
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_last |-> !busy)
        else $error("busy after final transaction");

    // a good result is a digit or a leading minus
    a_ok_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_OK |->
            (o_out_char >= CH_ZERO && o_out_char <= CH_NINE) ||
            (o_out_char >= CH_UA && o_out_char <= CH_UF) ||
            (o_out_char == CH_MINUS && !o_out_last))
        else $error("bad output character");

endmodule

bind radix_string_converter_core rsc_checker u_rsc_checker (.*);
